[hw/rtl/mrba_pkg.sv]
// ----------------------------------------------------------------------------
// mrba_pkg: shared constants of the multi-region bump allocator
// Command codes, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package mrba_pkg;

  // Parameter defaults
  localparam int MAX_REGIONS_DEF = 16;
  localparam int ADDR_WIDTH_DEF  = 32;

  // Fixed port field widths
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Region count after reset
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

endpackage : mrba_pkg

`default_nettype wire

[hw/rtl/multi_region_bump_allocator_unit.sv]
// ----------------------------------------------------------------------------
// multi_region_bump_allocator_unit: bump allocator over a region table
// Loads region entries and serves allocate requests by a forward scan.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with cmd and the payload fields; the request is taken on a
//   clock edge where start is high and busy is low. busy stays high while a
//   request is in progress. Every request gives exactly one result, shown on
//   alloc_address / alloc_ok for one cycle with done high; the receiver must
//   take it in that cycle.
//   A load request writes one table entry and answers in the next cycle.
//   An allocate request with zero size or on an exhausted table answers in
//   the next cycle. Otherwise the scan checks one region per cycle through a
//   single subtract/compare unit fed by the registered table read, starting
//   at the current region; a grant then updates the bump pointer in the
//   grant state. A new request may be taken in the cycle the result shows.
//   region_count is written through region_count_wr / region_count; the user
//   must do this only while the unit is idle; the unit does not enforce it.
//   Reset sets region 0 current, clears the exhausted flag and sets
//   region_count to 1; table entries hold nothing until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_region_bump_allocator_unit #(
  parameter int MAX_REGIONS = mrba_pkg::MAX_REGIONS_DEF,
  parameter int ADDR_WIDTH  = mrba_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          region_count_wr,
  input  wire logic [mrba_pkg::COUNT_W-1:0]  region_count,
  // request
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cmd,
  input  wire logic [mrba_pkg::INDEX_W-1:0]  entry_index,
  input  wire logic [mrba_pkg::DATA_W-1:0]   region_start,
  input  wire logic [mrba_pkg::DATA_W-1:0]   region_limit,
  input  wire logic [mrba_pkg::DATA_W-1:0]   request_bytes,
  // result
  output logic                               done,
  output logic [mrba_pkg::DATA_W-1:0]        alloc_address,
  output logic                               alloc_ok
);

  localparam int RW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int NW   = ((RW > mrba_pkg::COUNT_W) ? RW : mrba_pkg::COUNT_W) + 1;
  localparam int CMPW = (ADDR_WIDTH > mrba_pkg::DATA_W) ? ADDR_WIDTH : mrba_pkg::DATA_W;
  localparam logic [NW-1:0] MAX_N = NW'(MAX_REGIONS);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_GRANT = 2'd2;

  logic [1:0]            state, state_next;
  logic [RW-1:0]         scan, scan_next;
  logic [RW-1:0]         current;
  logic                  exhausted;
  logic [mrba_pkg::COUNT_W-1:0] count_reg;
  logic [mrba_pkg::DATA_W-1:0]  bytes;
  logic                  exact;

  // Region table memories
  logic [ADDR_WIDTH-1:0] limit_mem [MAX_REGIONS];
  logic [ADDR_WIDTH-1:0] bump_mem  [MAX_REGIONS];
  logic [ADDR_WIDTH-1:0] limit_q, bump_q;

  // Shared compare unit
  logic [CMPW-1:0] lim_x, bump_x, bytes_x, space;
  logic            fits, fills;
  logic [NW-1:0]   scan_inc, bound;
  logic            last_region;

  logic accept, load_ok, alloc_quick_fail;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign load_ok = (NW'(entry_index) < MAX_N);
  assign alloc_quick_fail = (request_bytes == '0) || exhausted;

  assign lim_x   = CMPW'(limit_q);
  assign bump_x  = CMPW'(bump_q);
  assign bytes_x = CMPW'(bytes);
  assign space   = (lim_x > bump_x) ? (lim_x - bump_x) : '0;
  assign fits    = (bytes_x <= space);
  assign fills   = (bytes_x == space);

  assign scan_inc = NW'(scan) + NW'(1);
  assign bound    = (NW'(count_reg) > MAX_N) ? MAX_N : NW'(count_reg);
  assign last_region = (scan_inc >= bound) || (scan_inc >= MAX_N);

  // Next state and scan pointer
  always_comb begin
    state_next = state;
    scan_next  = scan;
    unique case (state)
      ST_IDLE: begin
        scan_next = current;
        if (accept && (cmd == mrba_pkg::CMD_ALLOC) && !alloc_quick_fail) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (fits) begin
          state_next = ST_GRANT;
        end else if (last_region) begin
          state_next = ST_IDLE;
        end else begin
          scan_next = scan_inc[RW-1:0];
        end
      end
      ST_GRANT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    limit_q <= limit_mem[scan_next];
    bump_q  <= bump_mem[scan_next];
    if (state == ST_IDLE && accept && cmd == mrba_pkg::CMD_LOAD && load_ok) begin
      limit_mem[RW'(entry_index)] <= ADDR_WIDTH'(region_limit);
      bump_mem[RW'(entry_index)]  <= ADDR_WIDTH'(region_start);
    end else if (state == ST_GRANT) begin
      bump_mem[scan] <= bump_q + ADDR_WIDTH'(bytes);
    end
  end

  // Hold request payload and scan flags
  always_ff @(posedge clk) begin
    if (accept) begin
      bytes <= request_bytes;
    end
    if (state == ST_CHECK) begin
      exact <= fills;
    end
  end

  // Control state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      scan          <= '0;
      current       <= '0;
      exhausted     <= 1'b0;
      count_reg     <= mrba_pkg::COUNT_RESET;
      done          <= 1'b0;
      alloc_ok      <= 1'b0;
      alloc_address <= '0;
    end else begin
      state <= state_next;
      scan  <= scan_next;
      done  <= 1'b0;
      if (region_count_wr) begin
        count_reg <= region_count;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd == mrba_pkg::CMD_LOAD) begin
              done          <= 1'b1;
              alloc_ok      <= load_ok;
              alloc_address <= '0;
              if (load_ok && entry_index == '0) begin
                current   <= '0;
                exhausted <= 1'b0;
              end
            end else if (alloc_quick_fail) begin
              done          <= 1'b1;
              alloc_ok      <= 1'b0;
              alloc_address <= '0;
            end
          end
        end
        ST_CHECK: begin
          // drop the request when the last region does not fit
          if (!fits && last_region) begin
            done          <= 1'b1;
            alloc_ok      <= 1'b0;
            alloc_address <= '0;
          end
        end
        ST_GRANT: begin
          done          <= 1'b1;
          alloc_ok      <= 1'b1;
          alloc_address <= mrba_pkg::DATA_W'(bump_q);
          // advance past a region that the grant filled exactly
          if (exact) begin
            if (scan_inc < bound) begin
              current <= scan_inc[RW-1:0];
            end else begin
              exhausted <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule : multi_region_bump_allocator_unit

`default_nettype wire

[hw/rtl/mrba_checker.sv]
// ----------------------------------------------------------------------------
// mrba_checker: port-level checks of the bump allocator
// Watches the request and result ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module mrba_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          cmd,
  input wire logic [mrba_pkg::DATA_W-1:0]   request_bytes,
  input wire logic                          done,
  input wire logic [mrba_pkg::DATA_W-1:0]   alloc_address,
  input wire logic                          alloc_ok
);

  // busy only starts from an accepted request
  a_busy_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // a result closes the request in progress
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  // failed requests carry a zero address (successful loads also do, but are not checked)
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !alloc_ok) |-> (alloc_address == '0))
    else $error("nonzero address on a failed request");

  // a load answers in the next cycle
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == mrba_pkg::CMD_LOAD) |=> done)
    else $error("load request not answered in one cycle");

  // a zero-size allocation fails at once
  a_zero_size_fails: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == mrba_pkg::CMD_ALLOC && request_bytes == '0)
      |=> (done && !alloc_ok))
    else $error("zero-size allocation did not fail at once");

endmodule : mrba_checker

bind multi_region_bump_allocator_unit mrba_checker u_mrba_checker (.*);

`default_nettype wire
